// ===== sv/bba_pkg.sv =====
// shared types, constants and helpers of the buddy block allocator
// used by bba_store, bba_ctrl and buddy_block_allocator
package bba_pkg;

    localparam int TREE_DEPTH_DEF     = 3;
    localparam int ROOTS_PER_POOL_DEF = 256;
    localparam int MAX_POOLS_DEF      = 8;

    localparam int ID_W    = 16;
    localparam int NODE_FW = 13;
    localparam int LINK_W  = 17;
    localparam int MARK_W  = 5;
    localparam int PAGE_W  = 11;
    localparam int LVL_W   = 3;
    localparam int STAT_W  = 3;
    localparam int LIM_W   = 4;

    localparam logic [LIM_W-1:0] TREE_LIMIT_RST = 4'd8;

    // mark bits and the link valid bit
    localparam int MK_INNER_BIT = 3;
    localparam int MK_FREE_BIT  = 4;
    localparam int LINK_V_BIT   = 16;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t STS_OK       = 3'd0;
    localparam status_t STS_TOO_DEEP = 3'd1;
    localparam status_t STS_NO_SPACE = 3'd2;
    localparam status_t STS_BAD_ID   = 3'd3;
    localparam status_t STS_NOT_FREE = 3'd4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic marks;
        logic nxt;
        logic prv;
    } mem_we_t;

    // level of a node from its index within its tree: floor(log2(idx + 1))
    function automatic logic [LVL_W-1:0] level_of(input logic [8:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i])
            begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/bba_store.sv =====
// node marks and free list link memories, with a registered (synchronous) read
// depends on bba_pkg
module bba_store #(
    parameter int DEPTH = 32768
) (
    input  logic                        clk,
    input  bba_pkg::mem_we_t            we,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    input  logic [$clog2(DEPTH)-1:0]    marks_waddr,
    input  logic [bba_pkg::MARK_W-1:0]  marks_wdata,
    input  logic [$clog2(DEPTH)-1:0]    next_waddr,
    input  logic [bba_pkg::LINK_W-1:0]  next_wdata,
    input  logic [$clog2(DEPTH)-1:0]    prev_waddr,
    input  logic [bba_pkg::LINK_W-1:0]  prev_wdata,
    output logic [bba_pkg::MARK_W-1:0]  marks_q,
    output logic [bba_pkg::LINK_W-1:0]  next_q,
    output logic [bba_pkg::LINK_W-1:0]  prev_q
);
    import bba_pkg::*;

    logic [MARK_W-1:0] marks_mem [0:DEPTH-1];
    logic [LINK_W-1:0] next_mem  [0:DEPTH-1];
    logic [LINK_W-1:0] prev_mem  [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we.marks)
        begin
            marks_mem[marks_waddr] <= marks_wdata;
        end
        if (we.nxt)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (we.prv)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        marks_q <= marks_mem[raddr];
        next_q  <= next_mem[raddr];
        prev_q  <= prev_mem[raddr];
    end

endmodule

// ===== sv/bba_ctrl.sv =====
// request sequencer: free list search, split, pool creation sweep, coalescing
// depends on bba_pkg, drives the memories in bba_store
module bba_ctrl #(
    parameter int TREE_DEPTH     = bba_pkg::TREE_DEPTH_DEF,
    parameter int ROOTS_PER_POOL = bba_pkg::ROOTS_PER_POOL_DEF,
    parameter int MAX_POOLS      = bba_pkg::MAX_POOLS_DEF,
    parameter int ADDR_W         = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        req_type,
    input  logic [2:0]                  alloc_level,
    input  logic [bba_pkg::ID_W-1:0]    free_id,
    input  logic [bba_pkg::LIM_W-1:0]   tree_limit,
    output logic                        busy,
    output logic                        done,
    output logic [bba_pkg::ID_W-1:0]    block_id,
    output logic [bba_pkg::PAGE_W-1:0]  page_offset,
    output logic [bba_pkg::STAT_W-1:0]  status,
    output logic [ADDR_W-1:0]           mem_raddr,
    input  logic [bba_pkg::MARK_W-1:0]  marks_q,
    input  logic [bba_pkg::LINK_W-1:0]  next_q,
    input  logic [bba_pkg::LINK_W-1:0]  prev_q,
    output bba_pkg::mem_we_t            mem_we,
    output logic [ADDR_W-1:0]           marks_waddr,
    output logic [bba_pkg::MARK_W-1:0]  marks_wdata,
    output logic [ADDR_W-1:0]           next_waddr,
    output logic [bba_pkg::LINK_W-1:0]  next_wdata,
    output logic [ADDR_W-1:0]           prev_waddr,
    output logic [bba_pkg::LINK_W-1:0]  prev_wdata
);
    import bba_pkg::*;

    localparam int NUM_LVL    = TREE_DEPTH + 1;
    localparam int LVL_IW     = $clog2(NUM_LVL);
    localparam int RI_W       = TREE_DEPTH + 1;
    localparam int ROOT_NODES = 1 << RI_W;
    localparam int POOL_NODES = ROOTS_PER_POOL * ROOT_NODES;
    localparam int NODE_W     = $clog2(POOL_NODES);

    localparam logic [NODE_FW-1:0] IDX_MASK = NODE_FW'(ROOT_NODES - 1);
    localparam logic [LVL_W-1:0]   DEPTH_L  = LVL_W'(TREE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEARCH, ST_UNLINK, ST_SPLIT_A, ST_SPLIT_B, ST_SPLIT_END,
        ST_SWEEP, ST_FREE_CHK, ST_COAL, ST_SIB_CHK, ST_MERGE, ST_PUSH_A, ST_PUSH_B
    } state_t;

    state_t                state_reg, state_next;
    logic [LINK_W-1:0]     heads_reg [0:NUM_LVL-1];
    logic [LINK_W-1:0]     heads_next [0:NUM_LVL-1];
    logic [LIM_W-1:0]      pool_count_reg, pool_count_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [ID_W-1:0]       sib_reg, sib_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [LVL_W-1:0]      want_reg, want_next;
    logic [LVL_W-1:0]      to_reg, to_next;
    logic                  create_reg, create_next;
    logic                  retried_reg, retried_next;
    logic                  merged_reg, merged_next;
    logic [NODE_W-1:0]     k_reg, k_next;
    logic                  done_reg, done_next;
    logic [ID_W-1:0]       block_id_reg, block_id_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    status_t               status_reg, status_next;

    function automatic logic [ADDR_W-1:0] slot(input logic [ID_W-1:0] id);
        logic [31:0] s;
        s = 32'(id[ID_W-1:NODE_FW]) * 32'(POOL_NODES) + 32'(id[NODE_FW-1:0]);
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [LVL_IW-1:0] hix(input logic [LVL_W-1:0] l);
        return l[LVL_IW-1:0];
    endfunction

    function automatic logic [PAGE_W-1:0] page_of(input logic [NODE_FW-1:0] nd,
                                                   input logic [LVL_W-1:0] d);
        logic [15:0] ir;
        logic [15:0] ix;
        logic [15:0] v;
        ir = 16'(nd >> RI_W);
        ix = 16'(nd & IDX_MASK);
        v  = (ir << TREE_DEPTH) + ((ix + 16'd1 - (16'd1 << d)) << (DEPTH_L - d));
        return v[PAGE_W-1:0];
    endfunction

    // node arithmetic on the current node
    logic [NODE_FW-1:0] nd, bs, ix, left_n, right_n, parent_n, sib_n;
    logic [ID_W-NODE_FW-1:0] pbits;
    logic [LVL_W-1:0]   nl;

    // free list search
    logic               found;
    logic [LVL_W-1:0]   fl;

    // sweep helpers
    logic [ID_W-NODE_FW-1:0] cpool;
    logic [NODE_FW-1:0]      kn;
    logic [RI_W-1:0]         kidx;
    logic [NODE_W-1:0]       kroot;

    always_comb
    begin
        nd       = id_reg[NODE_FW-1:0];
        pbits    = id_reg[ID_W-1:NODE_FW];
        bs       = nd & ~IDX_MASK;
        ix       = nd & IDX_MASK;
        left_n   = bs | ((ix << 1) + NODE_FW'(1));
        right_n  = bs | ((ix << 1) + NODE_FW'(2));
        parent_n = bs | ((ix - NODE_FW'(1)) >> 1);
        sib_n    = bs | (ix[0] ? ix + NODE_FW'(1) : ix - NODE_FW'(1));
        nl       = lvl_reg + LVL_W'(1);
        cpool    = pool_count_reg[ID_W-NODE_FW-1:0];
        kn       = NODE_FW'(k_reg);
        kidx     = k_reg[RI_W-1:0];
        kroot    = k_reg >> RI_W;
        found    = 1'b0;
        fl       = '0;
        for (int i = 0; i < NUM_LVL; i++) begin
            if (LVL_W'(i) <= want_reg && heads_reg[i][LINK_V_BIT])
            begin
                found = 1'b1;
                fl    = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        heads_next      = heads_reg;
        pool_count_next = pool_count_reg;
        id_next         = id_reg;
        sib_next        = sib_reg;
        lvl_next        = lvl_reg;
        want_next       = want_reg;
        to_next         = to_reg;
        create_next     = create_reg;
        retried_next    = retried_reg;
        merged_next     = merged_reg;
        k_next          = k_reg;
        done_next       = 1'b0;
        block_id_next   = block_id_reg;
        page_next       = page_reg;
        status_next     = status_reg;
        mem_raddr       = slot(id_reg);
        mem_we          = '0;
        marks_waddr     = slot(id_reg);
        marks_wdata     = '0;
        next_waddr      = slot(id_reg);
        next_wdata      = '0;
        prev_waddr      = slot(id_reg);
        prev_wdata      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    block_id_next = '0;
                    page_next     = '0;
                    if (req_type == REQ_ALLOC)
                    begin
                        if (alloc_level > DEPTH_L)
                        begin
                            status_next = STS_TOO_DEEP;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            want_next    = alloc_level;
                            retried_next = 1'b0;
                            state_next   = ST_SEARCH;
                        end
                    end
                    else if (LIM_W'(free_id[ID_W-1:NODE_FW]) >= pool_count_reg ||
                             32'(free_id[NODE_FW-1:0]) >= 32'(POOL_NODES))
                    begin
                        status_next = STS_BAD_ID;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        id_next     = free_id;
                        mem_raddr   = slot(free_id);
                        merged_next = 1'b0;
                        state_next  = ST_FREE_CHK;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (found)
                begin
                    id_next    = heads_reg[hix(fl)][ID_W-1:0];
                    mem_raddr  = slot(heads_reg[hix(fl)][ID_W-1:0]);
                    lvl_next   = fl;
                    state_next = ST_UNLINK;
                end
                else if (!retried_reg && pool_count_reg < tree_limit &&
                         32'(pool_count_reg) < 32'(MAX_POOLS))
                begin
                    retried_next = 1'b1;
                    k_next       = '0;
                    state_next   = ST_SWEEP;
                end
                else
                begin
                    status_next = STS_NO_SPACE;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_UNLINK:
            begin
                // the head has no predecessor, so its successor gets an empty back link
                heads_next[hix(lvl_reg)] = next_q;
                if (next_q[LINK_V_BIT])
                begin
                    mem_we.prv = 1'b1;
                    prev_waddr = slot(next_q[ID_W-1:0]);
                    prev_wdata = '0;
                end
                to_next     = want_reg;
                create_next = 1'b0;
                state_next  = (lvl_reg < want_reg) ? ST_SPLIT_A : ST_SPLIT_END;
            end

            ST_SPLIT_A:
            begin
                sib_next       = {pbits, right_n};
                mem_we         = '{marks: 1'b1, nxt: 1'b1, prv: 1'b1};
                marks_waddr    = slot({pbits, right_n});
                marks_wdata    = MARK_W'(nl);
                marks_wdata[MK_FREE_BIT] = 1'b1;
                next_waddr     = slot({pbits, right_n});
                next_wdata     = heads_reg[hix(nl)];
                prev_waddr     = slot({pbits, right_n});
                prev_wdata     = '0;
                state_next     = ST_SPLIT_B;
            end

            ST_SPLIT_B:
            begin
                mem_we.marks = 1'b1;
                marks_wdata  = MARK_W'(lvl_reg);
                marks_wdata[MK_INNER_BIT] = 1'b1;
                if (heads_reg[hix(nl)][LINK_V_BIT])
                begin
                    mem_we.prv = 1'b1;
                    prev_waddr = slot(heads_reg[hix(nl)][ID_W-1:0]);
                    prev_wdata = {1'b1, sib_reg};
                end
                heads_next[hix(nl)] = {1'b1, sib_reg};
                id_next    = {pbits, left_n};
                lvl_next   = nl;
                state_next = (nl < to_reg) ? ST_SPLIT_A : ST_SPLIT_END;
            end

            ST_SPLIT_END:
            begin
                mem_we.marks = 1'b1;
                marks_wdata  = MARK_W'(to_reg);
                if (create_reg)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    block_id_next = id_reg;
                    page_next     = page_of(nd, to_reg);
                    status_next   = STS_OK;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                marks_waddr = slot({cpool, kn});
                next_waddr  = slot({cpool, kn});
                prev_waddr  = slot({cpool, kn});
                if (kidx == '0)
                begin
                    mem_we.marks = 1'b1;
                    marks_wdata  = '0;
                    marks_wdata[MK_FREE_BIT] = 1'b1;
                    // roots other than the first chain up in ascending order
                    if (kroot != '0)
                    begin
                        mem_we.nxt = 1'b1;
                        mem_we.prv = 1'b1;
                        if (32'(kroot) == 32'(ROOTS_PER_POOL - 1))
                        begin
                            next_wdata = heads_reg[0];
                        end
                        else
                        begin
                            next_wdata = {1'b1, cpool, kn + NODE_FW'(ROOT_NODES)};
                        end
                        if (kroot >= NODE_W'(2))
                        begin
                            prev_wdata = {1'b1, cpool, kn - NODE_FW'(ROOT_NODES)};
                        end
                    end
                end
                else if (kidx != RI_W'(ROOT_NODES - 1))
                begin
                    mem_we.marks = 1'b1;
                    marks_wdata  = MARK_W'(level_of(9'(kidx) + 9'd1));
                    marks_wdata[MK_INNER_BIT] = 1'b1;
                end
                k_next = k_reg + NODE_W'(1);
                if (k_reg == NODE_W'(POOL_NODES - 1))
                begin
                    heads_next[0]   = {1'b1, cpool, NODE_FW'(ROOT_NODES)};
                    pool_count_next = pool_count_reg + LIM_W'(1);
                    id_next         = {cpool, NODE_FW'(0)};
                    lvl_next        = '0;
                    to_next         = DEPTH_L;
                    create_next     = 1'b1;
                    state_next      = ST_SPLIT_A;
                end
            end

            ST_FREE_CHK:
            begin
                if (ix == IDX_MASK || marks_q[MK_FREE_BIT] || marks_q[MK_INNER_BIT] ||
                    marks_q[LVL_W-1:0] > DEPTH_L)
                begin
                    status_next = STS_NOT_FREE;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    lvl_next   = marks_q[LVL_W-1:0];
                    state_next = ST_COAL;
                end
            end

            ST_COAL:
            begin
                if (lvl_reg != '0)
                begin
                    sib_next   = {pbits, sib_n};
                    mem_raddr  = slot({pbits, sib_n});
                    state_next = ST_SIB_CHK;
                end
                else
                begin
                    state_next = ST_PUSH_A;
                end
            end

            ST_SIB_CHK:
            begin
                if (marks_q[MK_FREE_BIT])
                begin
                    mem_we.marks = 1'b1;
                    marks_waddr  = slot(sib_reg);
                    marks_wdata  = MARK_W'(lvl_reg);
                    marks_wdata[MK_INNER_BIT] = 1'b1;
                    // take the buddy out of its list
                    if (prev_q[LINK_V_BIT])
                    begin
                        mem_we.nxt = 1'b1;
                        next_waddr = slot(prev_q[ID_W-1:0]);
                        next_wdata = next_q;
                    end
                    else
                    begin
                        heads_next[hix(lvl_reg)] = next_q;
                    end
                    if (next_q[LINK_V_BIT])
                    begin
                        mem_we.prv = 1'b1;
                        prev_waddr = slot(next_q[ID_W-1:0]);
                        prev_wdata = prev_q;
                    end
                    state_next = ST_MERGE;
                end
                else
                begin
                    state_next = ST_PUSH_A;
                end
            end

            ST_MERGE:
            begin
                mem_we.marks = 1'b1;
                marks_wdata  = MARK_W'(lvl_reg);
                marks_wdata[MK_INNER_BIT] = 1'b1;
                id_next      = {pbits, parent_n};
                lvl_next     = lvl_reg - LVL_W'(1);
                merged_next  = 1'b1;
                state_next   = ST_COAL;
            end

            ST_PUSH_A:
            begin
                mem_we      = '{marks: 1'b1, nxt: 1'b1, prv: 1'b1};
                marks_wdata = MARK_W'(lvl_reg);
                marks_wdata[MK_INNER_BIT] = merged_reg;
                marks_wdata[MK_FREE_BIT]  = 1'b1;
                next_wdata  = heads_reg[hix(lvl_reg)];
                prev_wdata  = '0;
                state_next  = ST_PUSH_B;
            end

            ST_PUSH_B:
            begin
                if (heads_reg[hix(lvl_reg)][LINK_V_BIT])
                begin
                    mem_we.prv = 1'b1;
                    prev_waddr = slot(heads_reg[hix(lvl_reg)][ID_W-1:0]);
                    prev_wdata = {1'b1, id_reg};
                end
                heads_next[hix(lvl_reg)] = {1'b1, id_reg};
                status_next = STS_OK;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pool_count_reg <= '0;
            done_reg       <= 1'b0;
            for (int i = 0; i < NUM_LVL; i++) begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pool_count_reg <= pool_count_next;
            done_reg       <= done_next;
            heads_reg      <= heads_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        sib_reg      <= sib_next;
        lvl_reg      <= lvl_next;
        want_reg     <= want_next;
        to_reg       <= to_next;
        create_reg   <= create_next;
        retried_reg  <= retried_next;
        merged_reg   <= merged_next;
        k_reg        <= k_next;
        block_id_reg <= block_id_next;
        page_reg     <= page_next;
        status_reg   <= status_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign block_id    = block_id_reg;
    assign page_offset = page_reg;
    assign status      = status_reg;

endmodule

// ===== sv/buddy_block_allocator.sv =====
// buddy block allocator top level: limit register, sequencer and node memories
// depends on bba_pkg, bba_ctrl and bba_store
//
// Requests: raise start with req_type, alloc_level and free_id; the beat is
// taken on an edge where busy is low. Every request gives exactly one result
// beat: done is high for one cycle with block_id, page_offset and status,
// and the receiver cannot hold it off. busy drops on the edge done rises, so
// a new request may be taken in the same cycle the result is shown.
// States per request, from the accepting edge until done rises:
//   allocate from a list: SEARCH, UNLINK, SPLIT_A/SPLIT_B per level, SPLIT_END
//   level too deep or bad id: answered from IDLE; not freeable: FREE_CHK
//   free: FREE_CHK, COAL, SIB_CHK and MERGE per buddy merged, then COAL
//   (with SIB_CHK when the buddy is in use), PUSH_A and PUSH_B
//   pool creation (an allocate that finds no free block of its size or
//   larger, within the pool limit): a sweep of one node a cycle over the
//   pool's 4096 nodes with the default sizes, plus the split of the
//   reserved page
// The free lists walk the node and link memories one read-modify-write at a
// time; each memory has one read and one write port.
// tree_limit is written through cfg_valid / cfg_ready while idle.
// Reset empties every list, clears the pool count and sets tree_limit to 8.
module buddy_block_allocator #(
    parameter int TREE_DEPTH     = bba_pkg::TREE_DEPTH_DEF,
    parameter int ROOTS_PER_POOL = bba_pkg::ROOTS_PER_POOL_DEF,
    parameter int MAX_POOLS      = bba_pkg::MAX_POOLS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [2:0]                  alloc_level,
    input  logic [bba_pkg::ID_W-1:0]    free_id,
    output logic                        done,
    output logic [bba_pkg::ID_W-1:0]    block_id,
    output logic [bba_pkg::PAGE_W-1:0]  page_offset,
    output logic [bba_pkg::STAT_W-1:0]  status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bba_pkg::LIM_W-1:0]   cfg_data
);
    import bba_pkg::*;

    localparam int DEPTH  = MAX_POOLS * ROOTS_PER_POOL * (1 << (TREE_DEPTH + 1));
    localparam int ADDR_W = $clog2(DEPTH);

    logic [LIM_W-1:0]  tree_limit_reg;
    logic [ADDR_W-1:0] raddr, marks_waddr, next_waddr, prev_waddr;
    logic [MARK_W-1:0] marks_wdata, marks_q;
    logic [LINK_W-1:0] next_wdata, prev_wdata, next_q, prev_q;
    mem_we_t           we;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_limit_reg <= TREE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tree_limit_reg <= cfg_data;
        end
    end

    bba_ctrl #(
        .TREE_DEPTH     (TREE_DEPTH),
        .ROOTS_PER_POOL (ROOTS_PER_POOL),
        .MAX_POOLS      (MAX_POOLS),
        .ADDR_W         (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .alloc_level (alloc_level),
        .free_id     (free_id),
        .tree_limit  (tree_limit_reg),
        .busy        (busy),
        .done        (done),
        .block_id    (block_id),
        .page_offset (page_offset),
        .status      (status),
        .mem_raddr   (raddr),
        .marks_q     (marks_q),
        .next_q      (next_q),
        .prev_q      (prev_q),
        .mem_we      (we),
        .marks_waddr (marks_waddr),
        .marks_wdata (marks_wdata),
        .next_waddr  (next_waddr),
        .next_wdata  (next_wdata),
        .prev_waddr  (prev_waddr),
        .prev_wdata  (prev_wdata)
    );

    bba_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk         (clk),
        .we          (we),
        .raddr       (raddr),
        .marks_waddr (marks_waddr),
        .marks_wdata (marks_wdata),
        .next_waddr  (next_waddr),
        .next_wdata  (next_wdata),
        .prev_waddr  (prev_waddr),
        .prev_wdata  (prev_wdata),
        .marks_q     (marks_q),
        .next_q      (next_q),
        .prev_q      (prev_q)
    );

endmodule

// ===== sim/buddy_block_allocator_tb.sv =====
// self-checking testbench for buddy_block_allocator: directed table then random requests
// depends on bba_pkg and the buddy_block_allocator rtl; predictor kept in this file
`timescale 1ns / 100ps

module buddy_block_allocator_tb;
    import bba_pkg::*;

    localparam int DEPTH      = 3;
    localparam int ROOTS      = 256;
    localparam int POOLS      = 8;
    localparam int TREE_NODES = 1 << (DEPTH + 1);
    localparam int POOL_NODES = ROOTS * TREE_NODES;
    localparam int ALL_NODES  = POOLS * POOL_NODES;
    localparam int NODE_MSK   = 8191;
    localparam int WATCHDOG   = 40000;
    localparam int N_RANDOM   = 930;
    localparam int N_DIRECTED = 20;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic req_type;
    logic [2:0] alloc_level;
    logic [ID_W-1:0] free_id;
    logic done;
    logic [ID_W-1:0] block_id;
    logic [PAGE_W-1:0] page_offset;
    logic [STAT_W-1:0] status;
    logic cfg_valid;
    logic cfg_ready;
    logic [LIM_W-1:0] cfg_data;

    buddy_block_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .alloc_level(alloc_level), .free_id(free_id),
        .done(done), .block_id(block_id), .page_offset(page_offset),
        .status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [PAGE_W-1:0] page;
        status_t           sts;
    } alloc_result_t;

    typedef struct {
        logic        rtype;
        logic [2:0]  lvl;
        logic [15:0] fid;
        logic        fixed;
        status_t     sts;
    } stim_row_t;

    // allocator shadow state
    logic [4:0]  sh_marks [ALL_NODES];
    logic [16:0] sh_next  [ALL_NODES];
    logic [16:0] sh_prev  [ALL_NODES];
    logic [16:0] sh_heads [DEPTH+1];
    int unsigned sh_pools;
    int unsigned sh_limit;

    alloc_result_t pending_results[$];
    logic [15:0]   live_blocks[$];
    stim_row_t     directed[N_DIRECTED];

    int errors;
    int mismatches;
    int issued;
    int n_results;
    int n_alloc_ok;
    int n_frees_ok;
    int n_fail_sts;
    int idle_cycles;
    bit calm;

    function automatic int unsigned slot(logic [15:0] id);
        int unsigned pl;
        int unsigned loc;
        pl  = id >> 13;
        loc = id & NODE_MSK;
        if (pl >= POOLS || loc >= POOL_NODES)
            return 0;
        return pl * POOL_NODES + loc;
    endfunction

    function automatic void push_free(logic [15:0] id, int unsigned lv);
        logic [16:0] h;
        h = sh_heads[lv];
        sh_prev[slot(id)] = '0;
        sh_next[slot(id)] = h;
        if (h[16])
            sh_prev[slot(h[15:0])] = {1'b1, id};
        sh_heads[lv] = {1'b1, id};
    endfunction

    function automatic void unlink_free(logic [15:0] id, int unsigned lv);
        logic [16:0] p;
        logic [16:0] n;
        p = sh_prev[slot(id)];
        n = sh_next[slot(id)];
        if (p[16])
            sh_next[slot(p[15:0])] = n;
        else
            sh_heads[lv] = n;
        if (n[16])
            sh_prev[slot(n[15:0])] = p;
    endfunction

    function automatic logic [15:0] split_to(logic [15:0] id, int unsigned lv, int unsigned to);
        logic [15:0] pb;
        int unsigned node;
        int unsigned bs;
        int unsigned ix;
        int unsigned rt;
        pb   = id & 16'hE000;
        node = id & NODE_MSK;
        while (lv < to)
        begin
            bs = node & ~(TREE_NODES - 1);
            ix = node & (TREE_NODES - 1);
            rt = bs | ((ix << 1) + 2);
            lv++;
            sh_marks[slot(pb | 16'(rt))] = 5'(lv) | 5'd16;
            push_free(pb | 16'(rt), lv);
            sh_marks[slot(pb | 16'(node))] = 5'(lv - 1) | 5'd8;
            node = bs | ((ix << 1) + 1);
        end
        sh_marks[slot(pb | 16'(node))] = 5'(to);
        return pb | 16'(node);
    endfunction

    function automatic void grow_pool();
        int unsigned p;
        int unsigned rt;
        int unsigned k;
        logic [15:0] id;
        p = sh_pools;
        for (int j = ROOTS - 1; j >= 0; j--)
        begin
            rt = j * TREE_NODES;
            id = 16'((p << 13) | rt);
            k  = rt + 1;
            if (j != 0)
                push_free(id, 0);
            sh_marks[slot(id)] = 5'd16;
            for (int lv = 1; lv <= DEPTH; lv++)
                for (int c = 0; c < (1 << lv); c++)
                begin
                    sh_marks[slot(16'((p << 13) | k))] = 5'(lv) | 5'd8;
                    k++;
                end
        end
        sh_pools = p + 1;
        void'(split_to(16'(p << 13), 0, DEPTH));
    endfunction

    function automatic logic [10:0] page_at(int unsigned loc, int unsigned d);
        int unsigned ir;
        int unsigned ix;
        ir = loc >> (DEPTH + 1);
        ix = loc & (TREE_NODES - 1);
        return 11'((ir << DEPTH) + ((ix + 1 - (1 << d)) << (DEPTH - d)));
    endfunction

    function automatic alloc_result_t predict_alloc(logic rtype, logic [2:0] lvl,
                                                    logic [15:0] fid);
        alloc_result_t r;
        logic [15:0] pb;
        logic [15:0] got;
        int unsigned node;
        int unsigned d;
        int unsigned bs;
        int unsigned ix;
        int unsigned sb;
        logic [4:0] m;
        r.id = '0;
        r.page = '0;
        r.sts = STS_OK;
        if (rtype == REQ_ALLOC)
        begin
            if (lvl > DEPTH)
            begin
                r.sts = STS_TOO_DEEP;
                return r;
            end
            for (int att = 0; att < 2; att++)
            begin
                for (int l = lvl; l >= 0; l--)
                    if (sh_heads[l][16])
                    begin
                        got = sh_heads[l][15:0];
                        unlink_free(got, l);
                        got = split_to(got, l, lvl);
                        r.id = got;
                        r.page = page_at(got & NODE_MSK, lvl);
                        return r;
                    end
                if (att == 0)
                begin
                    if (sh_pools < sh_limit && sh_pools < POOLS)
                        grow_pool();
                    else
                        break;
                end
            end
            r.sts = STS_NO_SPACE;
            return r;
        end
        pb   = fid & 16'hE000;
        node = fid & NODE_MSK;
        if ((fid >> 13) >= sh_pools || node >= POOL_NODES)
        begin
            r.sts = STS_BAD_ID;
            return r;
        end
        m = sh_marks[slot(fid)];
        d = m[2:0];
        if ((node & (TREE_NODES - 1)) == TREE_NODES - 1 || m[4] || m[3] || d > DEPTH)
        begin
            r.sts = STS_NOT_FREE;
            return r;
        end
        forever
        begin
            bs = node & ~(TREE_NODES - 1);
            ix = node & (TREE_NODES - 1);
            if (d > 0)
            begin
                sb = bs | ((ix & 1) ? ix + 1 : ix - 1);
                if (sh_marks[slot(pb | 16'(sb))][4])
                begin
                    sh_marks[slot(pb | 16'(sb))] = 5'(d) | 5'd8;
                    sh_marks[slot(pb | 16'(node))] = 5'(d) | 5'd8;
                    unlink_free(pb | 16'(sb), d);
                    node = bs | ((ix - 1) >> 1);
                    d--;
                    continue;
                end
            end
            sh_marks[slot(pb | 16'(node))] = sh_marks[slot(pb | 16'(node))] | 5'd16;
            push_free(pb | 16'(node), d);
            break;
        end
        return r;
    endfunction

    // output side: done cannot be held off, so check every strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat id=%h page=%h status=%0d",
                             block_id, page_offset, status);
            end
            else
            begin
                alloc_result_t e;
                e = pending_results.pop_front();
                if (e.id !== block_id || e.page !== page_offset || e.sts !== status)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp id=%h page=%h status=%0d, got id=%h page=%h status=%0d",
                                 e.id, e.page, e.sts, block_id, page_offset, status);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat or result beat
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired");
            $display("buddy_block_allocator_tb failed");
            $finish;
        end
    end

    task automatic send_request(logic rtype, logic [2:0] lvl, logic [15:0] fid,
                                logic fixed, status_t sts);
        alloc_result_t r;
        while (!calm && $urandom_range(99) < 37)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= rtype;
        alloc_level <= lvl;
        free_id     <= fid;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_alloc(rtype, lvl, fid);
        if (fixed && r.sts !== sts)
        begin
            errors++;
            $display("directed row status %0d differs from table %0d", r.sts, sts);
        end
        if (rtype == REQ_ALLOC && r.sts == STS_OK)
        begin
            live_blocks.push_back(r.id);
            n_alloc_ok++;
        end
        if (rtype == REQ_FREE && r.sts == STS_OK)
            n_frees_ok++;
        if (r.sts != STS_OK)
            n_fail_sts++;
        pending_results.push_back(r);
        issued++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIM_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sh_limit = v;
    endtask

    initial
    begin
        logic [15:0] fid;
        logic [2:0]  lvl;
        int          k;
        int          pick;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = 1'b0;
        alloc_level = '0;
        free_id = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        mismatches = 0;
        issued = 0;
        n_results = 0;
        n_alloc_ok = 0;
        n_frees_ok = 0;
        n_fail_sts = 0;
        idle_cycles = 0;
        calm = 1'b0;
        for (int i = 0; i < ALL_NODES; i++)
        begin
            sh_marks[i] = '0;
            sh_next[i] = '0;
            sh_prev[i] = '0;
        end
        for (int i = 0; i <= DEPTH; i++)
            sh_heads[i] = '0;
        sh_pools = 0;
        sh_limit = TREE_LIMIT_RST;

        // directed: bad ids before any pool, too deep levels, reserved page, extremes
        directed[0]  = '{REQ_FREE,  3'd0, 16'h0000, 1'b1, STS_BAD_ID};
        directed[1]  = '{REQ_FREE,  3'd7, 16'hFFFF, 1'b1, STS_BAD_ID};
        directed[2]  = '{REQ_ALLOC, 3'd7, 16'h0000, 1'b1, STS_TOO_DEEP};
        directed[3]  = '{REQ_ALLOC, 3'd4, 16'hFFFF, 1'b1, STS_TOO_DEEP};
        directed[4]  = '{REQ_ALLOC, 3'd3, 16'h0000, 1'b1, STS_OK};
        directed[5]  = '{REQ_ALLOC, 3'd0, 16'h0000, 1'b1, STS_OK};
        directed[6]  = '{REQ_ALLOC, 3'd1, 16'h0000, 1'b0, STS_OK};
        directed[7]  = '{REQ_ALLOC, 3'd2, 16'h0000, 1'b0, STS_OK};
        directed[8]  = '{REQ_FREE,  3'd0, 16'h000F, 1'b1, STS_NOT_FREE};
        directed[9]  = '{REQ_FREE,  3'd0, 16'h0020, 1'b1, STS_NOT_FREE};
        directed[10] = '{REQ_FREE,  3'd0, 16'h0000, 1'b1, STS_NOT_FREE};
        directed[11] = '{REQ_FREE,  3'd0, 16'h0007, 1'b0, STS_OK};
        directed[12] = '{REQ_FREE,  3'd0, 16'h1000, 1'b1, STS_BAD_ID};
        directed[13] = '{REQ_FREE,  3'd0, 16'h1FFF, 1'b1, STS_BAD_ID};
        directed[14] = '{REQ_FREE,  3'd0, 16'h2000, 1'b1, STS_BAD_ID};
        directed[15] = '{REQ_FREE,  3'd0, 16'h0FFF, 1'b1, STS_NOT_FREE};
        directed[16] = '{REQ_ALLOC, 3'd3, 16'h0000, 1'b0, STS_OK};
        directed[17] = '{REQ_ALLOC, 3'd3, 16'h0000, 1'b0, STS_OK};
        directed[18] = '{REQ_FREE,  3'd0, 16'h0008, 1'b0, STS_OK};
        directed[19] = '{REQ_ALLOC, 3'd5, 16'h0000, 1'b1, STS_TOO_DEEP};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed[i].rtype, directed[i].lvl, directed[i].fid,
                         directed[i].fixed, directed[i].sts);

        // limit of one: a second pool is refused, whole pool gets drained in chunks
        write_limit(4'd1);
        k = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 300 && i < 400);
            if (i == 250)
                drain();
            if (i == 500)
                write_limit(4'd2);
            if (i == 700)
                write_limit(4'd0);
            if (i == 800)
                write_limit(4'd15);
            pick = $urandom_range(99);
            if (pick < 50 || live_blocks.size() == 0)
            begin
                // allocate: mostly legal levels, a few too deep; level 0 drains fastest
                lvl = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4))
                                                : 3'($urandom_range(DEPTH));
                if (i < 250 && $urandom_range(1))
                    lvl = 3'd0;
                send_request(REQ_ALLOC, lvl, 16'($urandom), 1'b0, STS_OK);
            end
            else if (pick < 85)
            begin
                k = $urandom_range(live_blocks.size() - 1);
                fid = live_blocks[k];
                live_blocks.delete(k);
                send_request(REQ_FREE, 3'($urandom), fid, 1'b0, STS_OK);
            end
            else
            begin
                // noise: random ids, double frees of live ids, neighbours
                fid = 16'($urandom);
                if ($urandom_range(1) && live_blocks.size() != 0)
                    fid = live_blocks[$urandom_range(live_blocks.size() - 1)] ^ 16'($urandom_range(3));
                if ((fid >> 13) < sh_pools || $urandom_range(3) == 0)
                    send_request(REQ_FREE, 3'($urandom), fid, 1'b0, STS_OK);
                else
                    send_request(REQ_FREE, 3'($urandom), fid & 16'h1FFF, 1'b0, STS_OK);
            end
        end
        drain();

        $display("%0d requests, %0d results: %0d allocations and %0d frees succeeded, %0d refused",
                 issued, n_results, n_alloc_ok, n_frees_ok, n_fail_sts);
        $display("pools created %0d, tree limits 8, 1, 2, 0 and 15 exercised", sh_pools);
        if (errors == 0)
            $display("buddy_block_allocator_tb passed");
        else
            $display("buddy_block_allocator_tb failed");
        $finish;
    end

endmodule
